// ===== src/heap_page_sbrk_allocator_defines.svh =====
// Assertion macros used by the checker file of the heap page allocator.
// No dependencies; include by bare file name.
`ifndef HEAP_PAGE_SBRK_ALLOCATOR_DEFINES_SVH
`define HEAP_PAGE_SBRK_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define HPSA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("heap allocator check failed: implication");

// Next-cycle implication, disabled while reset is low.
`define HPSA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("heap allocator check failed: next cycle");

`endif

// ===== src/hpsa_pkg.sv =====
// Shared types and constants of the heap page sbrk allocator.
// No dependencies; imported by every module of the block.
package hpsa_pkg;

    localparam int HEAP_PAGES_DEF = 32;
    localparam int PROCESSES_DEF  = 8;
    localparam int PAGE_SHIFT_DEF = 22;

    localparam int PROC_FIELD_W  = 3;
    localparam int DELTA_W       = 32;
    localparam int ADDR_W        = 32;
    localparam int STATUS_W      = 2;
    localparam int IN_TDATA_W    = 40;
    localparam int OUT_TDATA_W   = 32;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOMEM = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    localparam int                PADDR_W       = 2;
    localparam logic [PADDR_W-1:0] REG_HEAP_BASE = 2'd0;

    localparam logic CMD_SBRK    = 1'b0;
    localparam logic CMD_DESTROY = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CALC,
        S_ROUND,
        S_DECIDE,
        S_ALLOC,
        S_REL_RD,
        S_REL_WR,
        S_FINISH
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic calc;
        logic round;
        logic alloc_step;
        logic rel_read;
        logic rel_free;
        logic commit;
        logic set_range;
        logic set_nomem;
        logic load_out;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic proc_bad;
        logic range_bad;
        logic destroy;
        logic grow;
        logic shrink;
        logic nomem;
        logic count_eq;
        logic out_free;
    } t_status;

endpackage

// ===== src/hpsa_datapath.sv =====
// Datapath of the heap page allocator: per-process heap state, page map,
// page list memory and result registers. Depends on hpsa_pkg.
module hpsa_datapath import hpsa_pkg::*; #(
    parameter int HEAP_PAGES = HEAP_PAGES_DEF,
    parameter int PROCESSES  = PROCESSES_DEF,
    parameter int PAGE_SHIFT = PAGE_SHIFT_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    output t_status                 o_status,
    input  logic [ADDR_W-1:0]       i_heap_base,
    input  logic                    i_req_command,
    input  logic [PROC_FIELD_W-1:0] i_req_process,
    input  logic [DELTA_W-1:0]      i_req_delta,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [STATUS_W-1:0]     o_out_status,
    output logic [ADDR_W-1:0]       o_out_brk
);

    localparam int HP_W      = $clog2(HEAP_PAGES);
    localparam int CNT_W     = $clog2(HEAP_PAGES + 1);
    localparam int PIDX_W    = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
    localparam int SIZE_W    = CNT_W + PAGE_SHIFT;
    localparam int MEM_DEPTH = PROCESSES << HP_W;
    localparam logic [32:0]     CAPACITY  = 33'(HEAP_PAGES) << PAGE_SHIFT;
    localparam logic [SIZE_W:0] PAGE_MASK = (SIZE_W + 1)'((1 << PAGE_SHIFT) - 1);

    logic                    r_command;
    logic [PROC_FIELD_W-1:0] r_proc;
    logic [DELTA_W-1:0]      r_delta;

    logic [SIZE_W-1:0]       r_heap_size [PROCESSES];
    logic [CNT_W-1:0]        r_page_count [PROCESSES];
    logic [HEAP_PAGES-1:0]   r_taken;
    logic [CNT_W-1:0]        r_free_cnt;

    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        r_target;
    logic [SIZE_W-1:0]       r_new_size;
    logic                    r_range_bad;
    logic [ADDR_W-1:0]       r_brk;
    logic [HP_W-1:0]         r_ptr;
    logic [HP_W-1:0]         r_rd_data;

    logic [STATUS_W-1:0]     r_res_status;
    logic [ADDR_W-1:0]       r_res_brk;
    logic                    r_out_valid;
    logic [STATUS_W-1:0]     r_out_status;
    logic [ADDR_W-1:0]       r_out_brk;

    logic [HP_W-1:0]         mem [MEM_DEPTH];

    logic                    w_proc_bad;
    logic [PIDX_W-1:0]       w_pidx;
    logic [33:0]             w_sum;
    logic [SIZE_W:0]         w_round;
    logic [CNT_W-1:0]        w_cnt_m1;
    logic                    w_ptr_free;
    logic                    w_rd_taken;

    assign w_proc_bad = 32'(r_proc) >= 32'(PROCESSES);
    assign w_pidx     = w_proc_bad ? '0 : PIDX_W'(r_proc);
    assign w_sum      = {{(34 - SIZE_W){1'b0}}, r_heap_size[w_pidx]}
                      + {{2{r_delta[DELTA_W-1]}}, r_delta};
    assign w_round    = {1'b0, r_new_size} + PAGE_MASK;
    assign w_cnt_m1   = r_count - 1'b1;
    assign w_ptr_free = (32'(r_ptr) < HEAP_PAGES) && !r_taken[r_ptr];
    assign w_rd_taken = (32'(r_rd_data) < HEAP_PAGES) && r_taken[r_rd_data];

    always_comb begin
        o_status           = '0;
        o_status.proc_bad  = w_proc_bad;
        o_status.range_bad = r_range_bad;
        o_status.destroy   = (r_command == CMD_DESTROY);
        o_status.grow      = r_target > r_count;
        o_status.shrink    = r_count > r_target;
        o_status.nomem     = r_free_cnt < (r_target - r_count);
        o_status.count_eq  = r_count == r_target;
        o_status.out_free  = !r_out_valid || i_out_ready;
    end

    // request, arithmetic and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_command <= i_req_command;
            r_proc    <= i_req_process;
            r_delta   <= i_req_delta;
        end
        if (i_cmd.calc) begin
            r_count     <= r_page_count[w_pidx];
            r_new_size  <= w_sum[SIZE_W-1:0];
            r_range_bad <= w_sum[33] || (w_sum[32:0] > CAPACITY);
            r_brk       <= i_heap_base + ADDR_W'(r_heap_size[w_pidx]);
        end
        if (i_cmd.round) begin
            r_target <= (r_command == CMD_DESTROY) ? '0 : w_round[SIZE_W-1:PAGE_SHIFT];
            r_ptr    <= '0;
        end
        if (i_cmd.alloc_step) begin
            r_ptr <= r_ptr + 1'b1;
            if (w_ptr_free) begin
                r_count <= r_count + 1'b1;
            end
        end
        if (i_cmd.rel_read) begin
            r_count <= w_cnt_m1;
        end
        if (i_cmd.commit) begin
            r_res_status <= ST_OK;
            r_res_brk    <= (r_command == CMD_DESTROY) ? '0 : r_brk;
        end
        if (i_cmd.set_range) begin
            r_res_status <= ST_RANGE;
            r_res_brk    <= '0;
        end
        if (i_cmd.set_nomem) begin
            r_res_status <= ST_NOMEM;
            r_res_brk    <= '0;
        end
        if (i_cmd.load_out) begin
            r_out_status <= r_res_status;
            r_out_brk    <= r_res_brk;
        end
    end

    // page list memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.alloc_step && w_ptr_free) begin
            mem[{w_pidx, r_count[HP_W-1:0]}] <= r_ptr;
        end
        if (i_cmd.rel_read) begin
            r_rd_data <= mem[{w_pidx, w_cnt_m1[HP_W-1:0]}];
        end
    end

    // stored heap state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taken     <= '0;
            r_free_cnt  <= CNT_W'(HEAP_PAGES);
            r_out_valid <= 1'b0;
            for (int i = 0; i < PROCESSES; i++) begin
                r_heap_size[i]  <= '0;
                r_page_count[i] <= '0;
            end
        end else begin
            if (i_cmd.alloc_step && w_ptr_free) begin
                r_taken[r_ptr] <= 1'b1;
                r_free_cnt     <= r_free_cnt - 1'b1;
            end
            if (i_cmd.rel_free && w_rd_taken) begin
                r_taken[r_rd_data] <= 1'b0;
                r_free_cnt         <= r_free_cnt + 1'b1;
            end
            if (i_cmd.commit) begin
                r_page_count[w_pidx] <= r_count;
                r_heap_size[w_pidx]  <= (r_command == CMD_DESTROY) ? '0 : r_new_size;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_status = r_out_status;
    assign o_out_brk    = r_out_brk;

endmodule

// ===== src/hpsa_ctrl.sv =====
// Controller state machine of the heap page allocator.
// Depends on hpsa_pkg; drives hpsa_datapath through t_cmd.
module hpsa_ctrl import hpsa_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_req_valid,
    output logic    o_req_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_CALC;
                end
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                n_state    = S_ROUND;
            end
            S_ROUND: begin
                o_cmd.round = 1'b1;
                n_state     = S_DECIDE;
            end
            S_DECIDE: begin
                if (i_status.proc_bad || (!i_status.destroy && i_status.range_bad)) begin
                    o_cmd.set_range = 1'b1;
                    n_state         = S_FINISH;
                end else if (i_status.grow && i_status.nomem) begin
                    o_cmd.set_nomem = 1'b1;
                    n_state         = S_FINISH;
                end else if (i_status.grow) begin
                    n_state = S_ALLOC;
                end else if (i_status.shrink) begin
                    n_state = S_REL_RD;
                end else begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_FINISH;
                end
            end
            S_ALLOC: begin
                // scan upward, taking free pages until the target is met
                if (i_status.count_eq) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_FINISH;
                end else begin
                    o_cmd.alloc_step = 1'b1;
                end
            end
            S_REL_RD: begin
                if (i_status.count_eq) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_FINISH;
                end else begin
                    o_cmd.rel_read = 1'b1;
                    n_state        = S_REL_WR;
                end
            end
            S_REL_WR: begin
                o_cmd.rel_free = 1'b1;
                n_state        = S_REL_RD;
            end
            S_FINISH: begin
                // hold until the output register can take the result
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== src/heap_page_sbrk_allocator.sv =====
// Top level of the heap page sbrk allocator: stream ports, APB register,
// controller and datapath. Depends on hpsa_pkg, hpsa_ctrl, hpsa_datapath.
//
//  port group   dir  contents
//  i_s_*        in   request: tuser = command, tdata = process_index, delta
//  o_m_*        out  result:  tuser = status,  tdata = previous_break
//  APB          in   heap_base_address at byte address 0
//
// One request at a time; a request passes through CALC, ROUND and DECIDE, then
// its page walk and a step to close the walk: a scan of pages upward when
// growing (up to HEAP_PAGES), and a page list memory read, then a map update,
// for each page released when shrinking or destroying.
// Synchronous active-low reset clears the page map and all heap sizes and
// counts at once; the page list memory is not cleared.
// A stalled result waits in the output register; the next request is taken
// once the result has moved there.
module heap_page_sbrk_allocator import hpsa_pkg::*; #(
    parameter int HEAP_PAGES = HEAP_PAGES_DEF,
    parameter int PROCESSES  = PROCESSES_DEF,
    parameter int PAGE_SHIFT = PAGE_SHIFT_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,   // [2:0] process_index, [34:3] delta
    input  logic                   i_s_tuser,   // [0] command
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,   // [31:0] previous_break
    output logic [STATUS_W-1:0]    o_m_tuser,   // [1:0] status
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    logic [ADDR_W-1:0] r_heap_base;
    t_cmd              w_cmd;
    t_status           w_status;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_HEAP_BASE) ? r_heap_base : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_base <= '0;
        end else if (psel && penable && pwrite && pready && (paddr == REG_HEAP_BASE)) begin
            r_heap_base <= pwdata;
        end
    end

    hpsa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_s_tvalid),
        .o_req_ready (o_s_tready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    hpsa_datapath #(
        .HEAP_PAGES (HEAP_PAGES),
        .PROCESSES  (PROCESSES),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_heap_base   (r_heap_base),
        .i_req_command (i_s_tuser),
        .i_req_process (i_s_tdata[PROC_FIELD_W-1:0]),
        .i_req_delta   (i_s_tdata[PROC_FIELD_W +: DELTA_W]),
        .o_out_valid   (o_m_tvalid),
        .i_out_ready   (i_m_tready),
        .o_out_status  (o_m_tuser),
        .o_out_brk     (o_m_tdata)
    );

endmodule

// ===== src/hpsa_checker.sv =====
// Port-level checks of the heap page sbrk allocator, bound to the top level.
// Depends on hpsa_pkg and heap_page_sbrk_allocator_defines.svh.
`include "heap_page_sbrk_allocator_defines.svh"

module hpsa_checker import hpsa_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_tvalid,
    input logic                   o_s_tready,
    input logic                   o_m_tvalid,
    input logic                   i_m_tready,
    input logic [OUT_TDATA_W-1:0] o_m_tdata,
    input logic [STATUS_W-1:0]    o_m_tuser,
    input logic                   pready
);

    logic w_status_known;
    logic w_error_result;

    assign w_status_known = (o_m_tuser == ST_OK) || (o_m_tuser == ST_NOMEM)
                         || (o_m_tuser == ST_RANGE);
    assign w_error_result = o_m_tvalid && (o_m_tuser != ST_OK);

    `HPSA_ASSERT_NEXT(a_result_held, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid)
    `HPSA_ASSERT_IMP(a_status_code, i_clk, i_rst_n, o_m_tvalid, w_status_known)
    `HPSA_ASSERT_IMP(a_error_no_break, i_clk, i_rst_n, w_error_result, o_m_tdata == '0)
    `HPSA_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, i_s_tvalid && o_s_tready, !o_s_tready)
    `HPSA_ASSERT_IMP(a_apb_ready, i_clk, i_rst_n, 1'b1, pready)

endmodule

bind heap_page_sbrk_allocator hpsa_checker u_hpsa_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .pready     (pready)
);

// ===== bench/heap_page_sbrk_allocator_tb.sv =====
// Self-checking bench for heap_page_sbrk_allocator: streams sbrk and destroy
// requests, tracks the page map, heap sizes and page lists itself and checks
// every answer in order. Depends on hpsa_pkg and the block's RTL.
module heap_page_sbrk_allocator_tb;
    import hpsa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          PAGES      = HEAP_PAGES_DEF;
    localparam int          PROCS      = PROCESSES_DEF;
    localparam int          SHIFT      = PAGE_SHIFT_DEF;
    localparam int          SIZE_W     = SHIFT + $clog2(PAGES) + 1;
    localparam int          COUNT_W    = $clog2(PAGES) + 1;
    localparam int          PNUM_W     = $clog2(PAGES);
    localparam longint      PAGE_BYTES = longint'(1) << SHIFT;
    localparam longint      CAPACITY   = longint'(PAGES) << SHIFT;
    localparam logic [31:0] PG         = 32'(PAGE_BYTES);
    localparam logic [31:0] CAP        = 32'(CAPACITY);
    localparam int          SETTLE     = 2 * PAGES + 16;

    typedef struct packed {
        logic                    cmd;
        logic [PROC_FIELD_W-1:0] pid;
        logic [DELTA_W-1:0]      delta;
    } heap_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   brk;
    } heap_answer_t;

    logic                   i_clk      = 1'b0;
    logic                   i_rst_n    = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata  = '0;   // [2:0] process_index, [34:3] delta
    logic                   i_s_tuser  = 1'b0; // [0] command
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;         // [31:0] previous_break
    logic [STATUS_W-1:0]    o_m_tuser;         // [1:0] status
    logic                   psel       = 1'b0;
    logic                   penable    = 1'b0;
    logic                   pwrite     = 1'b0;
    logic [PADDR_W-1:0]     paddr      = '0;
    logic [31:0]            pwdata     = '0;
    logic [31:0]            prdata;
    logic                   pready;

    heap_page_sbrk_allocator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // Shadow of the allocator state.
    logic [31:0]         heap_base;
    logic                pg_taken [PAGES];
    logic [SIZE_W-1:0]   hp_size  [PROCS];
    logic [COUNT_W-1:0]  pg_count [PROCS];
    logic [PNUM_W-1:0]   pg_list  [PROCS][PAGES];

    heap_req_t    pending_req[$];
    heap_answer_t answers_due[$];
    heap_req_t    req_on_bus;
    logic         req_busy   = 1'b0;
    int           req_gap    = 0;
    int           stall_left = 0;
    int           errors     = 0;
    logic         no_idle    = 1'b0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Work out the answer to one accepted request and advance the shadow state.
    task automatic apply_heap_request(input heap_req_t rq);
        heap_answer_t ans;
        longint       nsz;
        int           npg;
        int           cnt;
        int           nfree;
        logic [31:0]  brk;
        ans = '{status: ST_OK, brk: '0};
        cnt = int'(pg_count[rq.pid]);
        if (rq.cmd == CMD_DESTROY) begin
            for (int i = 0; i < cnt; i++)
                pg_taken[pg_list[rq.pid][i]] = 1'b0;
            hp_size[rq.pid]  = '0;
            pg_count[rq.pid] = '0;
        end else begin
            nsz = longint'(hp_size[rq.pid]) + longint'($signed(rq.delta));
            if (nsz < 0 || nsz > CAPACITY) begin
                ans.status = ST_RANGE;
            end else begin
                npg = int'((nsz + PAGE_BYTES - 1) >>> SHIFT);
                brk = heap_base + 32'(hp_size[rq.pid]);
                if (npg > cnt) begin
                    nfree = 0;
                    for (int i = 0; i < PAGES; i++)
                        if (!pg_taken[i])
                            nfree++;
                    if (nfree < npg - cnt) begin
                        ans.status = ST_NOMEM;
                    end else begin
                        // take the lowest free pages, append to the list
                        for (int i = 0; i < PAGES && cnt < npg; i++) begin
                            if (!pg_taken[i]) begin
                                pg_taken[i] = 1'b1;
                                pg_list[rq.pid][cnt] = PNUM_W'(i);
                                cnt++;
                            end
                        end
                    end
                end else begin
                    while (cnt > npg) begin
                        cnt--;
                        pg_taken[pg_list[rq.pid][cnt]] = 1'b0;
                    end
                end
                if (ans.status == ST_OK) begin
                    pg_count[rq.pid] = COUNT_W'(cnt);
                    hp_size[rq.pid]  = SIZE_W'(nsz);
                    ans.brk          = brk;
                end
            end
        end
        answers_due.push_back(ans);
    endtask

    // Request driver.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                apply_heap_request(req_on_bus);
                req_busy = 1'b0;
            end
            if (!req_busy) begin
                if (req_gap > 0) begin
                    req_gap--;
                    i_s_tvalid <= 1'b0;
                end else if (pending_req.size() > 0) begin
                    req_on_bus = pending_req.pop_front();
                    req_busy   = 1'b1;
                    req_gap    = idle_len();
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= {5'b0, req_on_bus.delta, req_on_bus.pid};
                    i_s_tuser  <= req_on_bus.cmd;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Answer monitor and backpressure.
    always @(posedge i_clk) begin
        heap_answer_t want;
        logic         rdy;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                if (answers_due.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected answer status %0d brk %h", $time,
                             o_m_tuser, o_m_tdata);
                end else begin
                    want = answers_due.pop_front();
                    if (o_m_tuser !== want.status) begin
                        errors++;
                        $display("%0t: status mismatch expected %0d actual %0d", $time,
                                 want.status, o_m_tuser);
                    end
                    if (o_m_tdata !== want.brk) begin
                        errors++;
                        $display("%0t: previous_break mismatch expected %h actual %h",
                                 $time, want.brk, o_m_tdata);
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
                if ($urandom_range(0, 99) < 20)
                    stall_left = idle_len();
            end
            i_m_tready <= rdy;
        end
    end

    task automatic push_req(input logic cmd, input int pid, input logic [31:0] delta);
        pending_req.push_back('{cmd: cmd, pid: PROC_FIELD_W'(pid), delta: delta});
    endtask

    // Hold until every request is answered and the block has settled.
    task automatic wait_drained();
        while (pending_req.size() > 0 || req_busy || answers_due.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_heap_base(input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_HEAP_BASE;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        heap_base = value;
    endtask

    task automatic random_phase(input int n);
        int          r;
        int          pid;
        int          k;
        logic [31:0] d;
        @(negedge i_clk);
        for (int j = 0; j < n; j++) begin
            r   = $urandom_range(0, 99);
            pid = ($urandom_range(0, 99) < 70) ? $urandom_range(0, 3) : $urandom_range(0, 7);
            k   = $urandom_range(0, 5);
            if (r < 10) begin
                push_req(CMD_DESTROY, pid, $urandom);
            end else begin
                if (r < 20)
                    d = $urandom;
                else if (r < 55)
                    d = (PG * k) + $urandom_range(0, PG - 1);
                else if (r < 78)
                    d = -((PG * k) + $urandom_range(0, PG - 1));
                else if (r < 90)
                    d = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 4096)
                                                    : -$urandom_range(0, 4096);
                else
                    d = ($urandom_range(0, 1) != 0) ? PG * k : -(PG * k);
                push_req(CMD_SBRK, pid, d);
            end
        end
    endtask

    initial begin
        heap_base = '0;
        for (int i = 0; i < PAGES; i++)
            pg_taken[i] = 1'b0;
        for (int p = 0; p < PROCS; p++) begin
            hp_size[p]  = '0;
            pg_count[p] = '0;
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_heap_base(32'h0000_0000);
        @(negedge i_clk);
        push_req(CMD_SBRK,    0, 32'd0);
        push_req(CMD_SBRK,    0, 32'd1);
        push_req(CMD_SBRK,    0, PG - 1);           // fills the first page exactly
        push_req(CMD_SBRK,    0, 32'd1);            // one byte into a second page
        push_req(CMD_SBRK,    0, -32'sd1);          // back to one page
        push_req(CMD_SBRK,    0, 32'h8000_0000);    // size below zero
        push_req(CMD_SBRK,    0, 32'h7FFF_FFFF);    // size above capacity
        push_req(CMD_SBRK,    1, PG * 3);
        push_req(CMD_SBRK,    2, PG * 2);
        push_req(CMD_DESTROY, 1, 32'd0);
        push_req(CMD_SBRK,    3, PG * 4 + 5);       // reuses freed low pages first
        push_req(CMD_SBRK,    2, -PG);
        push_req(CMD_SBRK,    7, CAP);              // not enough pages free
        push_req(CMD_DESTROY, 0, 32'd0);
        push_req(CMD_DESTROY, 2, 32'd0);
        push_req(CMD_DESTROY, 3, 32'd0);
        push_req(CMD_SBRK,    7, CAP);              // whole map
        push_req(CMD_SBRK,    6, 32'd1);
        push_req(CMD_SBRK,    7, 32'd1);
        push_req(CMD_SBRK,    7, -CAP);
        push_req(CMD_DESTROY, 4, 32'hFFFF_FFFF);    // empty heap, delta ignored
        push_req(CMD_SBRK,    5, -32'sd1);
        push_req(CMD_DESTROY, 7, 32'h8000_0000);
        push_req(CMD_SBRK,    6, CAP - 1);
        push_req(CMD_DESTROY, 6, 32'd0);
        wait_drained();

        write_heap_base(32'hFFFF_FFFF);
        random_phase(106);
        wait_drained();

        write_heap_base($urandom);
        no_idle = 1'b1;
        random_phase(106);
        wait_drained();
        no_idle = 1'b0;

        write_heap_base(32'h8000_0000);
        random_phase(106);
        wait_drained();

        write_heap_base($urandom);
        random_phase(106);
        wait_drained();

        write_heap_base(32'h0000_0000);
        random_phase(106);
        wait_drained();

        if (errors == 0 && answers_due.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #8_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
